@@ src/sid_pkg.sv @@
// Package for the set intersection block: depth default, action and status codes, sequencer states.
`default_nettype none
package sid_pkg;

  localparam int unsigned SetDepthDefault = 256;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_PROBE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    STS_CLEARED = 3'd0,
    STS_LOADED  = 3'd1,
    STS_FULL    = 3'd2,
    STS_MATCH   = 3'd3,
    STS_NOMATCH = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SEQ_IDLE  = 3'b001,
    SEQ_MSCAN = 3'b010,
    SEQ_RSCAN = 3'b100
  } seq_state_e;

endpackage
`default_nettype wire

@@ src/set_intersection_dedup.sv @@
// Duplicate-free set intersection: member and result stores, one shared compare per cycle.
//
//   channel  direction  handshake                 payload
//   command  in         start_i, busy_o           action_i, value_i
//   result   out        done_o (one-cycle strobe) status_o, match_value_o, result_index_o
//
// Clear and load complete on acceptance; the result strobe follows on the next cycle.
// A probe scans the member store then the result store through registered
// memory reads and one 32-bit comparator.
// Reset empties both stores by clearing their fill counts; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module set_intersection_dedup #(
  parameter int unsigned SET_DEPTH = sid_pkg::SetDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         action_i,
  input  wire logic signed [31:0] value_i,
  output logic                    done_o,
  output logic [2:0]              status_o,
  output logic signed [31:0]      match_value_o,
  output logic [7:0]              result_index_o
);

  localparam int unsigned CW = $clog2(SET_DEPTH + 1);
  localparam int unsigned AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam logic [CW-1:0] DepthC = CW'(SET_DEPTH);

  sid_pkg::seq_state_e state_q, state_d;
  logic [CW-1:0] mcount_q, mcount_d;
  logic [CW-1:0] rcount_q, rcount_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          pend_q, pend_d;
  logic [31:0]   val_q, val_d;

  logic          done_q, done_d;
  logic [2:0]    status_q, status_d;
  logic [31:0]   mval_q, mval_d;
  logic [7:0]    ridx_q, ridx_d;

  logic [31:0]   member_mem [SET_DEPTH];
  logic [31:0]   result_mem [SET_DEPTH];
  logic [31:0]   m_rd_q, r_rd_q;
  logic [31:0]   cmp_data;
  logic          m_we, r_we;
  logic [AW-1:0] rd_addr;
  logic          accept;
  logic          hit;

  assign accept   = start_i && (state_q == sid_pkg::SEQ_IDLE);
  assign rd_addr  = idx_q[AW-1:0];
  assign cmp_data = (state_q == sid_pkg::SEQ_MSCAN) ? m_rd_q : r_rd_q;
  assign hit      = pend_q && (cmp_data == val_q) &&
                    ((state_q == sid_pkg::SEQ_MSCAN) || (state_q == sid_pkg::SEQ_RSCAN));

  always_comb begin
    state_d  = state_q;
    mcount_d = mcount_q;
    rcount_d = rcount_q;
    idx_d    = idx_q;
    pend_d   = 1'b0;
    val_d    = val_q;
    done_d   = 1'b0;
    status_d = status_q;
    mval_d   = mval_q;
    ridx_d   = ridx_q;
    m_we     = 1'b0;
    r_we     = 1'b0;
    case (state_q)
      sid_pkg::SEQ_IDLE: begin
        if (accept) begin
          val_d  = value_i;
          mval_d = '0;
          ridx_d = '0;
          case (action_i)
            sid_pkg::ACT_CLEAR: begin
              mcount_d = '0;
              rcount_d = '0;
              status_d = sid_pkg::STS_CLEARED;
              done_d   = 1'b1;
            end
            sid_pkg::ACT_LOAD: begin
              if (mcount_q < DepthC) begin
                m_we     = 1'b1;
                mcount_d = mcount_q + 1'b1;
                status_d = sid_pkg::STS_LOADED;
              end else begin
                status_d = sid_pkg::STS_FULL;
              end
              done_d = 1'b1;
            end
            sid_pkg::ACT_PROBE: begin
              idx_d   = '0;
              state_d = sid_pkg::SEQ_MSCAN;
            end
            default: begin
              status_d = sid_pkg::STS_NOMATCH;
              done_d   = 1'b1;
            end
          endcase
        end
      end
      sid_pkg::SEQ_MSCAN: begin
        if (hit) begin
          idx_d   = '0;
          state_d = sid_pkg::SEQ_RSCAN;
        end else if (idx_q == mcount_q) begin
          status_d = sid_pkg::STS_NOMATCH;
          done_d   = 1'b1;
          state_d  = sid_pkg::SEQ_IDLE;
        end else begin
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end
      end
      sid_pkg::SEQ_RSCAN: begin
        if (hit) begin
          status_d = sid_pkg::STS_NOMATCH;
          done_d   = 1'b1;
          state_d  = sid_pkg::SEQ_IDLE;
        end else if (idx_q == rcount_q) begin
          if (rcount_q < DepthC) begin
            r_we     = 1'b1;
            rcount_d = rcount_q + 1'b1;
            status_d = sid_pkg::STS_MATCH;
            mval_d   = val_q;
            ridx_d   = 8'(rcount_q);
          end else begin
            status_d = sid_pkg::STS_NOMATCH;
          end
          done_d  = 1'b1;
          state_d = sid_pkg::SEQ_IDLE;
        end else begin
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end
      end
      default: begin
        state_d = sid_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sid_pkg::SEQ_IDLE;
      mcount_q <= '0;
      rcount_q <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      mcount_q <= mcount_d;
      rcount_q <= rcount_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    status_q <= status_d;
    mval_q   <= mval_d;
    ridx_q   <= ridx_d;
  end

  // member store: write at fill count, registered read
  always_ff @(posedge clk_i) begin
    if (m_we) begin
      member_mem[mcount_q[AW-1:0]] <= value_i;
    end
    m_rd_q <= member_mem[rd_addr];
  end

  // result store
  always_ff @(posedge clk_i) begin
    if (r_we) begin
      result_mem[rcount_q[AW-1:0]] <= val_q;
    end
    r_rd_q <= result_mem[rd_addr];
  end

  assign busy_o         = (state_q != sid_pkg::SEQ_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign match_value_o  = mval_q;
  assign result_index_o = ridx_q;

endmodule
`default_nettype wire
